### rtl/dwr_pkg.sv
// Shared types and constants of the double-ended queue with reverse.
// Used by dwr_ring_add and deque_with_reverse_top; depends on nothing else.
package dwr_pkg;

  localparam int unsigned DEPTH_DEFAULT = 32;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_REVERSE   = 3'd4,
    CMD_LIST      = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ENTRY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_LOAD
  } state_e;

endpackage

### rtl/dwr_ring_add.sv
// Shared ring address adder: (base + offset) modulo DEPTH.
// Depends on dwr_pkg for the default depth.
module dwr_ring_add
  import dwr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic [AW-1:0] base_i,
  input  logic [AW-1:0] offset_i,
  output logic [AW-1:0] addr_o
);

  logic [AW:0] sum;

  always_comb begin
    sum = {1'b0, base_i} + {1'b0, offset_i};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    addr_o = sum[AW-1:0];
  end

endmodule

### rtl/deque_with_reverse_top.sv
// Top level of the double-ended queue with reverse: sequencer, ring store, output register.
// Depends on dwr_pkg and dwr_ring_add.
//
// Channel  Dir  Fields (low bit up)
// s_axis   in   tuser: cmd[2:0]; tdata: value[31:0]
// m_axis   out  tuser: status[1:0]; tdata: item[31:0]; tlast: last
//
// Insert, delete, reverse and a failed command run in the execute state, which holds on an output stall.
// A list reads each entry through the single read port of the store, then loads it into the output register.
// Reset clears the pointers, the count, the reversed flag and the output valid flag.
// A stalled output holds the sequencer; a new transaction is taken only in the idle state.
module deque_with_reverse_top
  import dwr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CMD_W-1:0]    s_axis_tuser_i,  // cmd[2:0]
  input  logic [VALUE_W-1:0]  s_axis_tdata_i,  // value[31:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [STATUS_W-1:0] m_axis_tuser_o,  // status[1:0]
  output logic [VALUE_W-1:0]  m_axis_tdata_o,  // item[31:0]
  output logic                m_axis_tlast_o
);

  state_e state_q, state_d;
  cmd_e   cmd_q;
  logic [VALUE_W-1:0] value_q;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] k_q, k_d;
  logic rev_q, rev_d;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [VALUE_W-1:0]  out_item_q;
  logic                out_last_q;

  logic                out_free;
  logic                out_load;
  status_e             out_status;
  logic [VALUE_W-1:0]  out_item;
  logic                out_last;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       ring_off;
  logic [AW-1:0]       ring_addr;
  logic [CW-1:0]       list_off;
  logic                full;
  logic                empty;
  logic                to_first;
  logic                accept;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign full     = (fill_q == CW'(DEPTH));
  assign empty    = (fill_q == '0);
  assign list_off = rev_q ? (fill_q - CW'(1) - k_q) : k_q;

  dwr_ring_add #(.DEPTH(DEPTH)) u_ring_add (
    .base_i   (front_q),
    .offset_i (ring_off),
    .addr_o   (ring_addr)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_LIST && !empty) begin
          state_d = S_RD;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          state_d = out_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    out_load   = 1'b0;
    out_status = ST_DONE;
    out_item   = '0;
    out_last   = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    ring_off   = list_off[AW-1:0];
    front_d    = front_q;
    fill_d     = fill_q;
    rev_d      = rev_q;
    k_d        = k_q;
    to_first   = 1'b0;
    case (state_q)
      S_EXEC: begin
        case (cmd_q)
          CMD_INS_FRONT, CMD_INS_BACK: begin
            to_first = (cmd_q == CMD_INS_FRONT) != rev_q;
            ring_off = to_first ? AW'(DEPTH - 1) : fill_q[AW-1:0];
            out_load = out_free;
            if (full) begin
              out_status = ST_FULL;
            end else if (out_free) begin
              mem_we = 1'b1;
              fill_d = fill_q + CW'(1);
              if (to_first) begin
                front_d = ring_addr;
              end
            end
          end
          CMD_DEL_FRONT, CMD_DEL_BACK: begin
            to_first = (cmd_q == CMD_DEL_FRONT) != rev_q;
            ring_off = AW'(1);
            out_load = out_free;
            if (empty) begin
              out_status = ST_EMPTY;
            end else if (out_free) begin
              fill_d = fill_q - CW'(1);
              if (to_first) begin
                front_d = ring_addr;
              end
            end
          end
          CMD_REVERSE: begin
            out_load = out_free;
            if (out_free) begin
              rev_d = !rev_q;
            end
          end
          CMD_LIST: begin
            k_d = '0;
            if (empty) begin
              out_load   = out_free;
              out_status = ST_EMPTY;
            end
          end
          default: begin
            out_load = out_free;
          end
        endcase
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_LOAD: begin
        out_status = ST_ENTRY;
        out_item   = rd_q;
        out_last   = (k_q + CW'(1) == fill_q);
        out_load   = out_free;
        if (out_free) begin
          k_d = k_q + CW'(1);
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      fill_q      <= '0;
      rev_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      fill_q  <= fill_d;
      rev_q   <= rev_d;
      k_q     <= k_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i;
    end
    if (out_load) begin
      out_status_q <= out_status;
      out_item_q   <= out_item;
      out_last_q   <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ring_addr] <= value_q;
    end
    if (mem_re) begin
      rd_q <= mem[ring_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = out_item_q;
  assign m_axis_tlast_o  = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("Fill count exceeds the store depth.");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q < AW'(DEPTH - 1) || front_q == AW'(DEPTH - 1))
    else $error("Front pointer is outside the ring.");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("An accepted transaction did not start execution.");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> $past(state_q) == S_RD || $past(state_q) == S_LOAD)
    else $error("List output stage entered without a store read.");

  a_list_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_LOAD) |-> k_q < fill_q)
    else $error("List index runs past the fill count.");

endmodule
